FILE: rtl/core/bfm_pkg.sv
// shared types, constants and divide helpers for the 3x3 box mean filter
package bfm_pkg;

  localparam int MAX_DIM  = 16;
  localparam int POS_W    = $clog2(MAX_DIM);
  localparam int SIDE_W   = 5;
  localparam int PIX_W    = 8;
  localparam int PSUM_W   = PIX_W + 2;
  localparam int SUM_W    = PIX_W + 4;
  localparam int RECIP_W  = 14;
  localparam int RECIP_SH = 15;
  localparam int NKIND    = 4;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(10);
  localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_DIM);

  // reciprocals scaled by 2^15, exact for every sum a mean can see
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(8192);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(5462);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(3641);

  typedef logic [2:0][PIX_W-1:0] col_t;   // [0] row r-2, [1] row r-1, [2] row r

  typedef struct packed {
    logic [2:0] rows;
    logic       col_en;
  } bfm_mask_t;

  typedef struct packed {
    logic full_rows;   // three rows of the neighbourhood inside the frame
    logic full_cols;   // three columns inside the frame
  } bfm_cnt_t;

  function automatic logic [RECIP_W-1:0] recip_sel(input bfm_cnt_t cnt);
    logic [RECIP_W-1:0] rv;
    rv = RECIP_4;
    if (cnt.full_rows && cnt.full_cols) rv = RECIP_9;
    else if (cnt.full_rows || cnt.full_cols) rv = RECIP_6;
    return rv;
  endfunction

  function automatic logic [SUM_W:0] max_sum(input bfm_cnt_t cnt);
    logic [SUM_W:0] mv;
    mv = (SUM_W + 1)'(4 * 255);
    if (cnt.full_rows && cnt.full_cols) mv = (SUM_W + 1)'(9 * 255);
    else if (cnt.full_rows || cnt.full_cols) mv = (SUM_W + 1)'(6 * 255);
    return mv;
  endfunction

endpackage

FILE: rtl/core/bfm_line_buf.sv
// two row stores holding the rows above the current one, indexed by column
module bfm_line_buf
  import bfm_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [POS_W-1:0] addr,
  input  logic [PIX_W-1:0] px,
  output logic [PIX_W-1:0] older_q,
  output logic [PIX_W-1:0] prior_q
);

  logic [PIX_W-1:0] older_r [MAX_DIM];
  logic [PIX_W-1:0] prior_r [MAX_DIM];

  assign older_q = older_r[addr];
  assign prior_q = prior_r[addr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_r[addr] <= prior_r[addr];
      prior_r[addr] <= px;
    end
  end

endmodule

FILE: rtl/core/bfm_col_cell.sv
// one window column: holds three pixels, passes them left, gives a masked column sum
module bfm_col_cell
  import bfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  col_t              col_in,
  input  bfm_mask_t         mask,
  output col_t              col_out,
  output logic [PSUM_W-1:0] psum
);

  col_t col_r;

  assign col_out = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    psum = '0;
    for (int i = 0; i < 3; i++) begin
      if (mask.col_en && mask.rows[i]) psum = psum + PSUM_W'(col_r[i]);
    end
  end

endmodule

FILE: rtl/core/bfm_mean_div.sv
// divide stage: sum times scaled reciprocal, registered into the output beat
module bfm_mean_div
  import bfm_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  logic [SUM_W-1:0] sum,
  input  bfm_cnt_t         cnt,
  output logic [PIX_W-1:0] mean_r
);

  logic [SUM_W+RECIP_W-1:0] prod;

  assign prod = (SUM_W + RECIP_W)'(sum) * (SUM_W + RECIP_W)'(recip_sel(cnt));

  always_ff @(posedge clk) begin
    if (load) mean_r <= prod[RECIP_SH +: PIX_W];
  end

endmodule

FILE: rtl/core/box_filter_3x3_edge_mean_unit.sv
// top level of the 3x3 box mean filter: counters, cell chain, result sequencing
// input: a new pixel beat is taken only after all results the last one caused (0 to 4) have
//   entered the shared sum stage, which walks them in turn and can be held by back-pressure
// reset: rst_n synchronous active low; clears counters, window cells, pending results,
//   output valid and sets frame_side to 10; the row stores are not cleared
module box_filter_3x3_edge_mean_unit
  import bfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] pixel
  input  logic [0:0]        in_tuser,    // [0] frame_start
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [7:0] mean_value, [11:8] out_row, [15:12] out_col
  output logic              out_tlast    // run_last
);

  logic [SIDE_W-1:0] side_r;
  logic [SIDE_W-1:0] side_now;
  logic [POS_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [POS_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [POS_W-1:0]  pos_r, pos_c;
  logic              wrap_pos;
  logic              in_acc;

  logic [NKIND-1:0]  pend_r, pend_nxt, pend_new, pend_left, sel_oh;
  logic [POS_W-1:0]  cur_row_r, cur_col_r;
  logic [SIDE_W-1:0] cur_side_r;

  logic [PIX_W-1:0]  older_q, prior_q;
  col_t              col_new;
  col_t              col_chain [3];
  bfm_mask_t         cell_mask [3];
  logic [PSUM_W-1:0] psum [3];

  logic              ro, co;
  logic [POS_W-1:0]  cen_row, cen_col;
  logic [2:0]        vr, vc, wrm, wcm;
  bfm_cnt_t          sel_cnt;

  logic              sum_vld_r;
  logic [SUM_W-1:0]  sum_r;
  bfm_cnt_t          cnt_r;
  logic [POS_W-1:0]  sum_row_r, sum_col_r;
  logic              sum_last_r;
  logic              sum_load, out_adv;

  logic              out_vld_r;
  logic [PIX_W-1:0]  mean_r;
  logic [POS_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
    end else if (cfg_valid) begin
      side_r <= cfg_data;
    end
  end

  always_comb begin
    side_now = side_r;
    if (side_r < SIDE_MIN) side_now = SIDE_MIN;
    if (side_r > SIDE_MAX) side_now = SIDE_MAX;
  end

  // position of the incoming pixel, restarting on frame_start or a shrunk side
  assign in_tready = (pend_r == '0);
  assign in_acc    = in_tvalid && in_tready;
  assign wrap_pos  = in_tuser[0] || ({1'b0, row_cnt_r} >= side_now)
                     || ({1'b0, col_cnt_r} >= side_now);
  assign pos_r     = wrap_pos ? '0 : row_cnt_r;
  assign pos_c     = wrap_pos ? '0 : col_cnt_r;

  always_comb begin
    row_cnt_nxt = pos_r;
    col_cnt_nxt = pos_c + POS_W'(1);
    if (({1'b0, pos_c} + SIDE_W'(1)) >= side_now) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (({1'b0, pos_r} + SIDE_W'(1)) >= side_now) ? '0 : pos_r + POS_W'(1);
    end
  end

  always_comb begin
    pend_new[0] = (pos_r != '0) && (pos_c != '0);
    pend_new[1] = (pos_r != '0) && (({1'b0, pos_c} + SIDE_W'(1)) == side_now);
    pend_new[2] = (({1'b0, pos_r} + SIDE_W'(1)) == side_now) && (pos_c != '0);
    pend_new[3] = (({1'b0, pos_r} + SIDE_W'(1)) == side_now)
                  && (({1'b0, pos_c} + SIDE_W'(1)) == side_now);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_acc) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_row_r  <= pos_r;
      cur_col_r  <= pos_c;
      cur_side_r <= side_now;
    end
  end

  bfm_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .addr    (pos_c),
    .px      (in_tdata[PIX_W-1:0]),
    .older_q (older_q),
    .prior_q (prior_q)
  );

  assign col_new = {in_tdata[PIX_W-1:0], prior_q, older_q};

  // chain of column cells, newest column on the right
  for (genvar j = 0; j < 3; j++) begin : g_cell
    bfm_col_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .col_in   ((j == 2) ? col_new : col_chain[(j == 2) ? 2 : j + 1]),
      .mask     (cell_mask[j]),
      .col_out  (col_chain[j]),
      .psum     (psum[j])
    );
  end

  // pick the earliest pending result and build its window mask
  assign sel_oh    = pend_r & (~pend_r + NKIND'(1));
  assign pend_left = pend_r & ~sel_oh;
  assign ro        = sel_oh[2] || sel_oh[3];
  assign co        = sel_oh[1] || sel_oh[3];
  assign cen_row   = ro ? cur_row_r : cur_row_r - POS_W'(1);
  assign cen_col   = co ? cur_col_r : cur_col_r - POS_W'(1);

  always_comb begin
    vr[0] = (cen_row != '0);
    vr[1] = 1'b1;
    vr[2] = (({1'b0, cen_row} + SIDE_W'(1)) != cur_side_r);
    vc[0] = (cen_col != '0);
    vc[1] = 1'b1;
    vc[2] = (({1'b0, cen_col} + SIDE_W'(1)) != cur_side_r);
    wrm   = ro ? {vr[1:0], 1'b0} : vr;
    wcm   = co ? {vc[1:0], 1'b0} : vc;
    sel_cnt.full_rows = &vr;
    sel_cnt.full_cols = &vc;
    for (int j = 0; j < 3; j++) begin
      cell_mask[j].rows   = wrm;
      cell_mask[j].col_en = wcm[j];
    end
  end

  assign out_adv  = sum_vld_r && (!out_vld_r || out_tready);
  assign sum_load = (pend_r != '0) && (!sum_vld_r || out_adv);

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc) pend_nxt = pend_new;
    else if (sum_load) pend_nxt = pend_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      sum_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (sum_load) sum_vld_r <= 1'b1;
      else if (out_adv) sum_vld_r <= 1'b0;
      if (out_adv) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_load) begin
      sum_r      <= SUM_W'(psum[0]) + SUM_W'(psum[1]) + SUM_W'(psum[2]);
      cnt_r      <= sel_cnt;
      sum_row_r  <= cen_row;
      sum_col_r  <= cen_col;
      sum_last_r <= (pend_left == '0);
    end
    if (out_adv) begin
      out_row_r  <= sum_row_r;
      out_col_r  <= sum_col_r;
      out_last_r <= sum_last_r;
    end
  end

  bfm_mean_div u_div (
    .clk    (clk),
    .load   (out_adv),
    .sum    (sum_r),
    .cnt    (cnt_r),
    .mean_r (mean_r)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_col_r, out_row_r, mean_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_vld_r |-> ({1'b0, sum_r} <= max_sum(cnt_r)))
    else $error("window sum exceeds its neighbour count");

  a_out_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(sum_vld_r))
    else $error("output beat without a summed result");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid || sum_vld_r || (pend_r != '0))
    else $error("run ended without a last beat");
`endif

endmodule

FILE: test/tb_box_filter_3x3_edge_mean_unit.sv
// testbench for the 3x3 box mean filter: directed table, then random frames checked by a predictor
`timescale 1ns / 1ps

module tb_box_filter_3x3_edge_mean_unit;
  import bfm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 350;
  localparam int N_DIRECTED   = 24;
  localparam int SETTLE       = 10;

  typedef struct packed {
    logic [7:0] mean_value;
    logic [3:0] out_row;
    logic [3:0] out_col;
    logic       run_last;
  } mean_result_t;

  // set_side writes the register before the beat; typed rows carry the mean by hand
  typedef struct packed {
    bit                set_side;
    logic [SIDE_W-1:0] side;
    logic [7:0]        pix;
    logic              fs;
    bit                typed;
    logic [7:0]        mean;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIDE_W-1:0] cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;    // [7:0] pixel
  logic [0:0]        in_tuser = '0;    // [0] frame_start
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;        // [7:0] mean_value, [11:8] out_row, [15:12] out_col
  logic              out_tlast;        // run_last

  // predictor state
  logic [7:0]        older_line [MAX_DIM];
  logic [7:0]        prior_line [MAX_DIM];
  bit [MAX_DIM-1:0]  older_written = '0;
  bit [MAX_DIM-1:0]  prior_written = '0;
  logic [7:0]        win [9];
  int                row_pos = 0;
  int                col_pos = 0;
  logic [SIDE_W-1:0] side_reg = SIDE_RESET;

  mean_result_t      expected_means [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  bit                quiet_sink = 1'b0;
  int                ready_hold = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    {1'b0, 5'd0,  8'd7,   1'b1, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd200, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd13,  1'b0, 1'b0, 8'd0},
    // side shrinks to 2 with the column counter already past it
    {1'b1, 5'd2,  8'd255, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd255, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd255, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd255, 1'b0, 1'b1, 8'd255},
    // next frame follows the wrap with no frame_start
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b1, 8'd0},
    // side 0 behaves as 2
    {1'b1, 5'd0,  8'd255, 1'b1, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd1,   1'b0, 1'b1, 8'd64},
    // 3x3 frame: corners, edges and one full window
    {1'b1, 5'd3,  8'd255, 1'b1, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd128, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd1,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd254, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd85,  1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd170, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd0,   1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd255, 1'b0, 1'b0, 8'd0},
    {1'b0, 5'd0,  8'd99,  1'b0, 1'b0, 8'd0}
  };

  box_filter_3x3_edge_mean_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  function automatic int side_now();
    int s;
    s = side_reg;
    if (s < 2) s = 2;
    if (s > MAX_DIM) s = MAX_DIM;
    return s;
  endfunction

  // mean at (cr,cc) over in-frame pixels held by the window whose newest pixel is (r,c)
  function automatic logic [7:0] neighbour_mean(int cr, int cc, int r, int c, int s);
    int sum, cnt, x, y, wr, wc, dx, dy;
    sum = 0;
    cnt = 0;
    for (dx = -1; dx <= 1; dx++) begin
      for (dy = -1; dy <= 1; dy++) begin
        x = cr + dx;
        y = cc + dy;
        wr = x - (r - 2);
        wc = y - (c - 2);
        if (x >= 0 && x < s && y >= 0 && y < s && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2) begin
          sum += win[wr * 3 + wc];
          cnt++;
        end
      end
    end
    return (cnt != 0) ? 8'(sum / cnt) : 8'd0;
  endfunction

  function automatic void predict_pixel(input logic [7:0] px, input logic fs, input bit typed,
                                        input logic [7:0] tmean);
    mean_result_t res [4];
    int s, r, c, n, k;
    s = side_now();
    if (fs || row_pos >= s || col_pos >= s) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    n = 0;
    for (k = 0; k < 3; k++) begin
      win[k * 3 + 0] = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = older_line[c];
    win[5] = prior_line[c];
    win[8] = px;
    older_line[c] = prior_line[c];
    older_written[c] = prior_written[c];
    prior_line[c] = px;
    prior_written[c] = 1'b1;

    if (r >= 1 && c >= 1) begin
      res[n] = {neighbour_mean(r - 1, c - 1, r, c, s), 4'(r - 1), 4'(c - 1), 1'b0};
      n++;
    end
    if (r >= 1 && c == s - 1) begin
      res[n] = {neighbour_mean(r - 1, c, r, c, s), 4'(r - 1), 4'(c), 1'b0};
      n++;
    end
    if (r == s - 1 && c >= 1) begin
      res[n] = {neighbour_mean(r, c - 1, r, c, s), 4'(r), 4'(c - 1), 1'b0};
      n++;
    end
    if (r == s - 1 && c == s - 1) begin
      res[n] = {neighbour_mean(r, c, r, c, s), 4'(r), 4'(c), 1'b0};
      n++;
    end
    if (n > 0) res[n - 1].run_last = 1'b1;
    for (k = 0; k < n; k++) begin
      if (typed) res[k].mean_value = tmean;
      expected_means.push_back(res[k]);
    end

    col_pos++;
    if (col_pos >= s) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= s) row_pos = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pixel(input logic [7:0] px, input logic fs, input bit typed,
                            input logic [7:0] tmean);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(px, fs, typed, tmean);
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_frame_side(input logic [SIDE_W-1:0] v);
    hold_until_drained();
    // pixels with no result may still be in flight
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    side_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result sink with random back-pressure
  always @(negedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (quiet_sink) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 4);
      end else if (r < 90) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    mean_result_t got, want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[11:8], out_tdata[15:12], out_tlast};
      if (expected_means.size() == 0) begin
        $error("unexpected result: mean_value %0d out_row %0d out_col %0d run_last %0d",
               got.mean_value, got.out_row, got.out_col, got.run_last);
        mismatch_count++;
      end else begin
        want = expected_means.pop_front();
        if (got.mean_value != want.mean_value) begin
          $error("mean_value: expected %0d, got %0d", want.mean_value, got.mean_value);
          mismatch_count++;
        end
        if (got.out_row != want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
          mismatch_count++;
        end
        if (got.out_col != want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
          mismatch_count++;
        end
        if (got.run_last != want.run_last) begin
          $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase, sent, i, s, n_items, n_max, drain_at;
    bit quiet_source, noisy, at_origin;
    logic [SIDE_W-1:0] side_val;
    logic [7:0] px;
    logic fs;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].set_side) set_frame_side(directed_rows[i].side);
      send_pixel(directed_rows[i].pix, directed_rows[i].fs, directed_rows[i].typed,
                 directed_rows[i].mean);
      idle_for(pick_gap());
    end

    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: side_val = 5'd16;
        1: side_val = 5'd31;
        2: side_val = 5'd1;
        3: side_val = 5'd17;
        4: side_val = 5'd2;
        default: side_val = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                        : 5'($urandom_range(2, 6));
      endcase
      set_frame_side(side_val);
      s = side_now();
      if (phase == 0) begin
        // one whole largest frame, which also fills both line stores
        n_items = s * s + 2;
        drain_at = 100;
      end else begin
        n_max = (s * s * 2 > 40) ? 40 : s * s * 2;
        n_items = $urandom_range(n_max, s);
        drain_at = -1;
      end
      noisy = (phase != 0);
      quiet_source = (phase != 0) && ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);

      for (i = 0; i < n_items; i++) begin
        at_origin = (row_pos == 0 && col_pos == 0) || row_pos >= s || col_pos >= s;
        if (i == 0 && !(&older_written)) fs = 1'b1;
        else if (at_origin) fs = 1'($urandom_range(0, 1));
        else fs = noisy && ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 9))
          0: px = 8'd0;
          1: px = 8'd255;
          default: px = 8'($urandom_range(0, 255));
        endcase
        send_pixel(px, fs, 1'b0, 8'd0);
        if (i == drain_at || $urandom_range(0, 79) == 0) hold_until_drained();
        else idle_for(quiet_source ? 0 : pick_gap());
      end
      sent += n_items;
      phase++;
    end

    quiet_sink = 1'b0;
    hold_until_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bfm_pkg.sv
rtl/core/bfm_line_buf.sv
rtl/core/bfm_col_cell.sv
rtl/core/bfm_mean_div.sv
rtl/core/box_filter_3x3_edge_mean_unit.sv
test/tb_box_filter_3x3_edge_mean_unit.sv
